// File: rtl/pulse_width_command_transmitter_assert.svh
// ---------------------------------------------------------------------------
// Pulse width command transmitter assertion macros
// Concurrent assertion helpers, used by the queue module. They compile to
// nothing when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef PULSE_WIDTH_COMMAND_TRANSMITTER_ASSERT_SVH
`define PULSE_WIDTH_COMMAND_TRANSMITTER_ASSERT_SVH
`ifndef SYNTHESIS
`define PWCT_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);
`define PWCT_ASSERT_NEXT(label, pre, post, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error(msg);
`else
`define PWCT_ASSERT(label, prop, msg)
`define PWCT_ASSERT_NEXT(label, pre, post, msg)
`endif
`endif

// File: rtl/pwct_pkg.sv
// ---------------------------------------------------------------------------
// Pulse width command transmitter package
// Shared constants, codes, types and helper functions.
// ---------------------------------------------------------------------------
`default_nettype none

package pwct_pkg;

   localparam int QUEUE_DEPTH = 8;
   localparam int FRAME_BITS  = 13;

   localparam int WORD_W    = 13;
   localparam int CNT_W     = 16;
   localparam int QPTR_W    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int FILL_W    = $clog2(QUEUE_DEPTH + 1);
   localparam int BIT_IDX_W = $clog2(FRAME_BITS + 1);

   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   localparam logic [CNT_W-1:0] HIGH_SAMPLES      = 16'd441;
   localparam logic [CNT_W-1:0] LOW_SAMPLES       = 16'd19;
   localparam logic [CNT_W-1:0] BIT_SAMPLES       = 16'd45;
   localparam logic [CNT_W-1:0] SHORT_BIT_SAMPLES = 16'd34;
   localparam logic [CNT_W-1:0] TICK_MAX          = 16'hFFFF;
   localparam int               SHORT_BIT_INDEX   = 2;

   localparam logic [1:0] REG_ALLOW_NO_RX = 2'd0;
   localparam logic [1:0] REG_HOLDOFF_TX  = 2'd1;
   localparam logic [1:0] REG_HOLDOFF_RX  = 2'd2;
   localparam logic [1:0] REG_TAIL_TICKS  = 2'd3;

   typedef enum logic [1:0] {
      CMD_TICK     = 2'd0,
      CMD_ENQUEUE  = 2'd1,
      CMD_RECEIVE  = 2'd2,
      CMD_RESERVED = 2'd3
   } cmd_type;

   typedef struct packed {
      logic             allow_no_rx;
      logic [CNT_W-1:0] holdoff_tx;
      logic [CNT_W-1:0] holdoff_rx;
      logic [CNT_W-1:0] tail_ticks;
   } cfg_type;

   typedef struct packed {
      logic              valid;
      logic [WORD_W-1:0] word;
   } load_type;

   typedef struct packed {
      logic              line_level;
      logic              driver_enable;
      logic              busy;
      logic              sent_done;
      logic [WORD_W-1:0] sent_word;
   } tx_result_type;

   function automatic logic [CNT_W-1:0] bit_samples(input logic [BIT_IDX_W-1:0] idx);
      logic [CNT_W-1:0] samples;
      samples = (idx == BIT_IDX_W'(SHORT_BIT_INDEX)) ? SHORT_BIT_SAMPLES : BIT_SAMPLES;
      return samples;
   endfunction

endpackage

`default_nettype wire

// File: rtl/pwct_ram.sv
// ---------------------------------------------------------------------------
// Generic single-clock RAM
// One write port and one read port with registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module pwct_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8
) (
   input  logic                                        clock,
   input  logic                                        wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                            wr_data,
   input  logic                                        rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                            rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: rtl/pwct_queue.sv
// ---------------------------------------------------------------------------
// Command word queue
// Circular queue of command words held in a RAM, with head and fill
// registers. A pop reads the head entry, which arrives in the next cycle.
// ---------------------------------------------------------------------------
`default_nettype none
`include "pulse_width_command_transmitter_assert.svh"

module pwct_queue (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         enq,
   input  logic [pwct_pkg::WORD_W-1:0]  enq_word,
   input  logic                         pop,
   output logic                         nonempty,
   output logic                         enq_ok,
   output logic [pwct_pkg::FILL_W-1:0]  count,
   output pwct_pkg::load_type           load
);
   import pwct_pkg::*;

   logic [QPTR_W-1:0] head_ff;
   logic [QPTR_W-1:0] head_in;
   logic [FILL_W-1:0] fill_ff;
   logic [FILL_W-1:0] fill_in;
   logic              load_valid_ff;
   logic [QPTR_W:0]   slot_sum;
   logic [QPTR_W-1:0] wr_slot;
   logic [WORD_W-1:0] rd_word;

   always_comb begin
      enq_ok   = enq && (fill_ff < FILL_W'(QUEUE_DEPTH));
      nonempty = (fill_ff != '0);
      slot_sum = {1'b0, head_ff} + (QPTR_W + 1)'(fill_ff);
      if (slot_sum >= (QPTR_W + 1)'(QUEUE_DEPTH)) begin
         wr_slot = QPTR_W'(slot_sum - (QPTR_W + 1)'(QUEUE_DEPTH));
      end else begin
         wr_slot = slot_sum[QPTR_W-1:0];
      end
      head_in = head_ff;
      fill_in = fill_ff;
      if (pop) begin
         head_in = (head_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_ff + 1'b1;
         fill_in = fill_ff - 1'b1;
      end else if (enq_ok) begin
         fill_in = fill_ff + 1'b1;
      end
      count      = fill_in;
      load.valid = load_valid_ff;
      load.word  = rd_word;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff       <= '0;
         fill_ff       <= '0;
         load_valid_ff <= 1'b0;
      end else begin
         head_ff       <= head_in;
         fill_ff       <= fill_in;
         load_valid_ff <= pop;
      end
   end

   pwct_ram #(
      .WIDTH (WORD_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (enq_ok),
      .wr_addr (wr_slot),
      .wr_data (enq_word),
      .rd_en   (pop),
      .rd_addr (head_ff),
      .rd_data (rd_word)
   );

   `PWCT_ASSERT(a_fill_bound, fill_ff <= FILL_W'(QUEUE_DEPTH), "queue fill exceeds depth")
   `PWCT_ASSERT(a_pop_nonempty, !pop || (fill_ff != '0), "pop from an empty queue")
   `PWCT_ASSERT(a_pop_enq_excl, !(pop && enq), "pop and enqueue in the same cycle")
   `PWCT_ASSERT_NEXT(a_fill_stable, !pop && !enq_ok, fill_ff == $past(fill_ff), "fill moved without cause")

endmodule

`default_nettype wire

// File: rtl/pwct_seq.sv
// ---------------------------------------------------------------------------
// Transmit sequencer
// Holdoff tracking, start decision and the phase, sample and bit counters
// that shape the pulse train on the line.
// ---------------------------------------------------------------------------
`default_nettype none

module pwct_seq (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    item_valid,
   input  pwct_pkg::cmd_type       item_cmd,
   input  pwct_pkg::cfg_type       cfg,
   input  logic                    queue_nonempty,
   input  pwct_pkg::load_type      load,
   output logic                    start,
   output pwct_pkg::tx_result_type result
);
   import pwct_pkg::*;

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_HIGH,
      PH_LOW,
      PH_BITS,
      PH_TAIL
   } phase_type;

   phase_type          phase_ff, phase_in, cur_phase;
   logic [CNT_W-1:0]   count_ff, count_in, cur_count, count_dec;
   logic [BIT_IDX_W-1:0] bit_idx_ff, bit_idx_in, cur_bit, bit_next;
   logic [WORD_W-1:0]  shift_ff, shift_in;
   logic [WORD_W-1:0]  active_ff, active_in;
   logic [CNT_W-1:0]   tx_ticks_ff, tx_ticks_in, tx_ticks_sat;
   logic [CNT_W-1:0]   rx_ticks_ff, rx_ticks_in, rx_ticks_sat;
   logic               seen_ff, seen_in;
   logic               tick;
   logic               may_start;

   always_comb begin
      tick = item_valid && (item_cmd == CMD_TICK);
      tx_ticks_sat = (tx_ticks_ff == TICK_MAX) ? tx_ticks_ff : tx_ticks_ff + 1'b1;
      rx_ticks_sat = (rx_ticks_ff == TICK_MAX) ? rx_ticks_ff : rx_ticks_ff + 1'b1;
      may_start = queue_nonempty && (cfg.allow_no_rx || seen_ff)
                  && (tx_ticks_sat >= cfg.holdoff_tx)
                  && (!seen_ff || (rx_ticks_sat >= cfg.holdoff_rx));
      start     = tick && (phase_ff == PH_IDLE) && may_start;
      cur_phase = start ? PH_HIGH : phase_ff;
      cur_count = start ? HIGH_SAMPLES : count_ff;
      cur_bit   = start ? '0 : bit_idx_ff;
      count_dec = (cur_count != '0) ? cur_count - 1'b1 : cur_count;
      bit_next  = cur_bit + 1'b1;

      phase_in    = phase_ff;
      count_in    = count_ff;
      bit_idx_in  = bit_idx_ff;
      shift_in    = shift_ff;
      active_in   = active_ff;
      tx_ticks_in = tx_ticks_ff;
      rx_ticks_in = rx_ticks_ff;
      seen_in     = seen_ff;
      result      = '0;

      if (load.valid) begin
         active_in = load.word;
         shift_in  = load.word;
      end

      if (tick) begin
         tx_ticks_in = tx_ticks_sat;
         rx_ticks_in = rx_ticks_sat;
         if (cur_phase != PH_IDLE) begin
            result.driver_enable = 1'b1;
            result.busy          = 1'b1;
            result.line_level    = (cur_phase == PH_HIGH)
                                   || ((cur_phase == PH_BITS) && shift_ff[WORD_W-1]);
            phase_in   = cur_phase;
            count_in   = count_dec;
            bit_idx_in = cur_bit;
            if (count_dec == '0) begin
               case (cur_phase)
                  PH_HIGH: begin
                     phase_in = PH_LOW;
                     count_in = LOW_SAMPLES;
                  end
                  PH_LOW: begin
                     phase_in   = PH_BITS;
                     bit_idx_in = '0;
                     count_in   = bit_samples('0);
                  end
                  PH_BITS: begin
                     bit_idx_in = bit_next;
                     shift_in   = {shift_ff[WORD_W-2:0], 1'b0};
                     if (bit_next >= BIT_IDX_W'(FRAME_BITS)) begin
                        if (cfg.tail_ticks == '0) begin
                           phase_in         = PH_IDLE;
                           count_in         = '0;
                           tx_ticks_in      = '0;
                           result.sent_done = 1'b1;
                           result.sent_word = active_ff;
                        end else begin
                           phase_in = PH_TAIL;
                           count_in = cfg.tail_ticks;
                        end
                     end else begin
                        count_in = bit_samples(bit_next);
                     end
                  end
                  PH_TAIL: begin
                     phase_in         = PH_IDLE;
                     count_in         = '0;
                     tx_ticks_in      = '0;
                     result.sent_done = 1'b1;
                     result.sent_word = active_ff;
                  end
                  default: begin
                     phase_in = PH_IDLE;
                  end
               endcase
            end
         end
      end else if (item_valid) begin
         if (item_cmd == CMD_RECEIVE) begin
            seen_in     = 1'b1;
            rx_ticks_in = '0;
         end
         result.driver_enable = (phase_ff != PH_IDLE);
         result.busy          = (phase_ff != PH_IDLE);
      end
   end

   always_ff @(posedge clock) begin
      shift_ff  <= shift_in;
      active_ff <= active_in;
      if (reset) begin
         phase_ff    <= PH_IDLE;
         count_ff    <= '0;
         bit_idx_ff  <= '0;
         tx_ticks_ff <= '0;
         rx_ticks_ff <= '0;
         seen_ff     <= 1'b0;
      end else begin
         phase_ff    <= phase_in;
         count_ff    <= count_in;
         bit_idx_ff  <= bit_idx_in;
         tx_ticks_ff <= tx_ticks_in;
         rx_ticks_ff <= rx_ticks_in;
         seen_ff     <= seen_in;
      end
   end

endmodule

`default_nettype wire

// File: rtl/pulse_width_command_transmitter.sv
// ---------------------------------------------------------------------------
// Pulse width command transmitter
// Queues command words and sends them as pulse-width frames on sample ticks.
// ---------------------------------------------------------------------------
// Each request word carries a command: a sample tick, an enqueue of a
// command word, or a frame received notice. Every accepted request word
// produces exactly one response word with the line level and driver enable
// for that sample, busy status, enqueue status, the finished word on the
// tick that ends a transmission, and the queue fill after the request.
// The response is registered and appears in the cycle after acceptance;
// one request word is accepted every cycle while the response side keeps
// up; the single output register sets that figure. When the receiver stalls,
// the output register holds its word and the request side is accepted again
// only in the cycle the response is taken. Queued words live in a RAM read
// as a transmission starts, long before the first bit is driven. Reset
// empties the queue, ends any transmission, clears the tick counters and
// restores the register defaults; no clearing pass is needed. The CSR port
// is an APB-style slave with four 32-bit registers at byte offsets 0, 4, 8
// and 12; the user must write them only while the block is idle, unenforced.
// ---------------------------------------------------------------------------
`default_nettype none

module pulse_width_command_transmitter (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [1:0]                        req_command,
   input  logic [pwct_pkg::WORD_W-1:0]       req_command_word,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic                              rsp_line_level,
   output logic                              rsp_driver_enable,
   output logic                              rsp_busy_res,
   output logic                              rsp_enqueue_ok,
   output logic                              rsp_sent_done,
   output logic [pwct_pkg::WORD_W-1:0]       rsp_sent_word,
   output logic [pwct_pkg::FILL_W-1:0]       rsp_queue_count,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [pwct_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [pwct_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [pwct_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                              csr_pready
);
   import pwct_pkg::*;

   cfg_type            cfg_ff;
   cfg_type            cfg_in;
   logic               csr_write;
   logic [1:0]         csr_index;
   logic               accept;
   cmd_type            item_cmd;
   logic               queue_nonempty;
   logic               enq_ok;
   logic [FILL_W-1:0]  queue_count;
   load_type           load;
   logic               start;
   tx_result_type      result;
   logic               rsp_valid_ff;
   logic               line_level_ff;
   logic               driver_enable_ff;
   logic               busy_ff;
   logic               enqueue_ok_ff;
   logic               sent_done_ff;
   logic [WORD_W-1:0]  sent_word_ff;
   logic [FILL_W-1:0]  queue_count_ff;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = csr_paddr[CSR_ADDR_W-1:2];

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (csr_index)
            REG_ALLOW_NO_RX: cfg_in.allow_no_rx = csr_pwdata[0];
            REG_HOLDOFF_TX:  cfg_in.holdoff_tx  = csr_pwdata[CNT_W-1:0];
            REG_HOLDOFF_RX:  cfg_in.holdoff_rx  = csr_pwdata[CNT_W-1:0];
            REG_TAIL_TICKS:  cfg_in.tail_ticks  = csr_pwdata[CNT_W-1:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         REG_ALLOW_NO_RX: csr_prdata = CSR_DATA_W'(cfg_ff.allow_no_rx);
         REG_HOLDOFF_TX:  csr_prdata = CSR_DATA_W'(cfg_ff.holdoff_tx);
         REG_HOLDOFF_RX:  csr_prdata = CSR_DATA_W'(cfg_ff.holdoff_rx);
         REG_TAIL_TICKS:  csr_prdata = CSR_DATA_W'(cfg_ff.tail_ticks);
         default:         csr_prdata = '0;
      endcase
   end

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign item_cmd  = cmd_type'(req_command);

   pwct_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .enq      (accept && (item_cmd == CMD_ENQUEUE)),
      .enq_word (req_command_word),
      .pop      (start),
      .nonempty (queue_nonempty),
      .enq_ok   (enq_ok),
      .count    (queue_count),
      .load     (load)
   );

   pwct_seq u_seq (
      .clock          (clock),
      .reset          (reset),
      .item_valid     (accept),
      .item_cmd       (item_cmd),
      .cfg            (cfg_ff),
      .queue_nonempty (queue_nonempty),
      .load           (load),
      .start          (start),
      .result         (result)
   );

   always_ff @(posedge clock) begin
      if (accept) begin
         line_level_ff    <= result.line_level;
         driver_enable_ff <= result.driver_enable;
         busy_ff          <= result.busy;
         enqueue_ok_ff    <= enq_ok;
         sent_done_ff     <= result.sent_done;
         sent_word_ff     <= result.sent_word;
         queue_count_ff   <= queue_count;
      end
      if (reset) begin
         cfg_ff.allow_no_rx <= 1'b0;
         cfg_ff.holdoff_tx  <= 16'd10000;
         cfg_ff.holdoff_rx  <= 16'd2000;
         cfg_ff.tail_ticks  <= 16'd1000;
         rsp_valid_ff       <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
         if (accept) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_line_level    = line_level_ff;
   assign rsp_driver_enable = driver_enable_ff;
   assign rsp_busy_res      = busy_ff;
   assign rsp_enqueue_ok    = enqueue_ok_ff;
   assign rsp_sent_done     = sent_done_ff;
   assign rsp_sent_word     = sent_word_ff;
   assign rsp_queue_count   = queue_count_ff;

endmodule

`default_nettype wire

// File: sim/tb_pulse_width_command_transmitter.sv
// ----------------------------------------------------------------------------
// Pulse width command transmitter testbench
// Drives command, enqueue and frame received words into the transmitter and
// compares every response word, field by field, with a cycle-exact software
// copy of the queue, holdoff counters and frame sequencer. A short directed
// table covers the reset state, a full queue and the unused command code.
// Random phases follow under several register settings, including the
// extremes, with idle gaps and a long response stall. Any frame in flight is
// run to completion before each register change.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_pulse_width_command_transmitter;
   timeunit 1ns;
   timeprecision 1ps;

   import pwct_pkg::*;

   localparam int CYCLE_LIMIT     = 1000000;
   localparam int PHASES          = 6;
   localparam int WORDS_PER_PHASE = 60;
   localparam int DIRECTED_ROWS   = 18;

   typedef enum logic [2:0] {TX_IDLE, TX_HIGH, TX_LOW, TX_BITS, TX_TAIL} tx_state_type;

   typedef struct packed {
      logic              line_level;
      logic              driver_enable;
      logic              busy_res;
      logic              enqueue_ok;
      logic              sent_done;
      logic [WORD_W-1:0] sent_word;
      logic [FILL_W-1:0] queue_count;
   } line_result_type;

   typedef struct packed {
      cmd_type           command;
      logic [WORD_W-1:0] word;
      logic              typed;
      logic              level;
      logic              enable;
      logic              busy;
      logic              accepted;
      logic              done;
      logic [WORD_W-1:0] sent;
      logic [FILL_W-1:0] count;
   } directed_row_type;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   logic [1:0]            req_command;
   logic [WORD_W-1:0]     req_command_word;
   logic                  rsp_valid;
   logic                  rsp_ready;
   logic                  rsp_line_level;
   logic                  rsp_driver_enable;
   logic                  rsp_busy_res;
   logic                  rsp_enqueue_ok;
   logic                  rsp_sent_done;
   logic [WORD_W-1:0]     rsp_sent_word;
   logic [FILL_W-1:0]     rsp_queue_count;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   cfg_type           cfg = '{1'b0, 16'd10000, 16'd2000, 16'd1000};
   logic [WORD_W-1:0] pending_words [QUEUE_DEPTH];
   int unsigned       pending_head = 0;
   int unsigned       pending_fill = 0;
   tx_state_type      tx_state = TX_IDLE;
   logic [CNT_W-1:0]  tx_count = '0;
   int unsigned       tx_bit = 0;
   logic [WORD_W-1:0] tx_shift = '0;
   logic [WORD_W-1:0] tx_word = '0;
   logic [CNT_W-1:0]  ticks_tx = '0;
   logic [CNT_W-1:0]  ticks_rx = '0;
   logic              rx_seen = 1'b0;

   line_result_type expected_lines [$];
   int              error_count = 0;
   int              req_idle_pct = 0;
   int              rsp_idle_pct = 0;
   int              rsp_hold_request = 0;
   int              cycle_count = 0;

   logic        phase_allow   [PHASES] = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0};
   logic [15:0] phase_hold_tx [PHASES] = '{16'd0, 16'hFFFF, 16'hFFFF, 16'd1000, 16'd2000,
                                          16'd0};
   logic [15:0] phase_hold_rx [PHASES] = '{16'd0, 16'd1, 16'd0, 16'd40, 16'd0, 16'hFFFF};
   logic [15:0] phase_tail    [PHASES] = '{16'd1, 16'd0, 16'd3, 16'd1200, 16'hFFFF, 16'd0};

   // Reset settings: sends need a received frame and wait 10000 ticks.
   directed_row_type directed_rows [DIRECTED_ROWS] = '{
      '{CMD_TICK,     13'h0000, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 13'h0, 4'd0},
      '{CMD_ENQUEUE,  13'h1FFF, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 13'h0, 4'd1},
      '{CMD_ENQUEUE,  13'h0000, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 13'h0, 4'd2},
      '{CMD_RESERVED, 13'h1555, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 13'h0, 4'd2},
      '{CMD_TICK,     13'h1FFF, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 13'h0, 4'd2},
      '{CMD_ENQUEUE,  13'h0AAA, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 13'h0, 4'd3},
      '{CMD_ENQUEUE,  13'h1555, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 13'h0, 4'd4},
      '{CMD_ENQUEUE,  13'h1000, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 13'h0, 4'd5},
      '{CMD_ENQUEUE,  13'h0001, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 13'h0, 4'd6},
      '{CMD_ENQUEUE,  13'h0FFF, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 13'h0, 4'd7},
      '{CMD_ENQUEUE,  13'h1E0F, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 13'h0, 4'd8},
      '{CMD_ENQUEUE,  13'h1234, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 13'h0, 4'd8},
      '{CMD_RECEIVE,  13'h0F0F, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 13'h0, 4'd8},
      '{CMD_TICK,     13'h0000, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 13'h0, 4'd8},
      '{CMD_RESERVED, 13'h1FFF, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 13'h0, 4'd8},
      '{CMD_ENQUEUE,  13'h0000, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 13'h0, 4'd8},
      '{CMD_TICK,     13'h1AAA, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 13'h0, 4'd0},
      '{CMD_RECEIVE,  13'h1FFF, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 13'h0, 4'd0}
   };

   pulse_width_command_transmitter dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_command       (req_command),
      .req_command_word  (req_command_word),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_line_level    (rsp_line_level),
      .rsp_driver_enable (rsp_driver_enable),
      .rsp_busy_res      (rsp_busy_res),
      .rsp_enqueue_ok    (rsp_enqueue_ok),
      .rsp_sent_done     (rsp_sent_done),
      .rsp_sent_word     (rsp_sent_word),
      .rsp_queue_count   (rsp_queue_count),
      .csr_psel          (csr_psel),
      .csr_penable       (csr_penable),
      .csr_pwrite        (csr_pwrite),
      .csr_paddr         (csr_paddr),
      .csr_pwdata        (csr_pwdata),
      .csr_prdata        (csr_prdata),
      .csr_pready        (csr_pready)
   );

   always #10 clock = ~clock;

   task automatic count_error(input string detail);
      error_count++;
      if (error_count <= 10) begin
         $display("mismatch: %s", detail);
      end
   endtask

   function automatic logic [CNT_W-1:0] saturating_tick(input logic [CNT_W-1:0] ticks);
      return (ticks == TICK_MAX) ? ticks : ticks + 1'b1;
   endfunction

   function automatic void finish_frame(inout line_result_type res);
      tx_state = TX_IDLE;
      tx_count = '0;
      ticks_tx = '0;
      res.sent_done = 1'b1;
      res.sent_word = tx_word;
   endfunction

   function automatic line_result_type transmit_step(input cmd_type cmd,
                                                     input logic [WORD_W-1:0] word);
      line_result_type res;
      logic            start_ok;
      res = '0;
      case (cmd)
         CMD_ENQUEUE: begin
            if (pending_fill < QUEUE_DEPTH) begin
               pending_words[(pending_head + pending_fill) % QUEUE_DEPTH] = word;
               pending_fill++;
               res.enqueue_ok = 1'b1;
            end
         end
         CMD_RECEIVE: begin
            rx_seen = 1'b1;
            ticks_rx = '0;
         end
         CMD_TICK: begin
            ticks_tx = saturating_tick(ticks_tx);
            ticks_rx = saturating_tick(ticks_rx);
            start_ok = (pending_fill != 0) && (cfg.allow_no_rx || rx_seen)
                       && (ticks_tx >= cfg.holdoff_tx)
                       && (!rx_seen || ticks_rx >= cfg.holdoff_rx);
            if (tx_state == TX_IDLE && start_ok) begin
               tx_word = pending_words[pending_head];
               pending_head = (pending_head + 1) % QUEUE_DEPTH;
               pending_fill--;
               tx_shift = tx_word;
               tx_bit = 0;
               tx_state = TX_HIGH;
               tx_count = HIGH_SAMPLES;
            end
            if (tx_state != TX_IDLE) begin
               res.line_level = (tx_state == TX_HIGH)
                                || (tx_state == TX_BITS && tx_shift[WORD_W-1]);
               res.driver_enable = 1'b1;
               res.busy_res = 1'b1;
               if (tx_count != 0) begin
                  tx_count--;
               end
               if (tx_count == 0) begin
                  case (tx_state)
                     TX_HIGH: begin
                        tx_state = TX_LOW;
                        tx_count = LOW_SAMPLES;
                     end
                     TX_LOW: begin
                        tx_state = TX_BITS;
                        tx_bit = 0;
                        tx_count = BIT_SAMPLES;
                     end
                     TX_BITS: begin
                        tx_bit++;
                        tx_shift = tx_shift << 1;
                        if (tx_bit >= FRAME_BITS) begin
                           if (cfg.tail_ticks == 0) begin
                              finish_frame(res);
                           end else begin
                              tx_state = TX_TAIL;
                              tx_count = cfg.tail_ticks;
                           end
                        end else begin
                           tx_count = (tx_bit == SHORT_BIT_INDEX) ? SHORT_BIT_SAMPLES
                                                                  : BIT_SAMPLES;
                        end
                     end
                     default: begin
                        finish_frame(res);
                     end
                  endcase
               end
            end
         end
         default: begin
         end
      endcase
      if (cmd != CMD_TICK && tx_state != TX_IDLE) begin
         res.driver_enable = 1'b1;
         res.busy_res = 1'b1;
      end
      res.queue_count = FILL_W'(pending_fill);
      return res;
   endfunction

   function automatic logic [WORD_W-1:0] any_command_word();
      case ($urandom_range(7))
         0: return '0;
         1: return '1;
         default: return WORD_W'($urandom);
      endcase
   endfunction

   task automatic offer_word(input cmd_type cmd, input logic [WORD_W-1:0] word,
                             input logic typed, input line_result_type typed_result);
      logic            accepted;
      line_result_type predicted;
      if ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < req_idle_pct);
      end
      req_valid <= 1'b1;
      req_command <= cmd;
      req_command_word <= word;
      accepted = 1'b0;
      while (!accepted) begin
         @(negedge clock);
         accepted = (req_ready === 1'b1);
         @(posedge clock);
      end
      predicted = transmit_step(cmd, word);
      expected_lines.push_back(typed ? typed_result : predicted);
   endtask

   task automatic drive_word(input cmd_type cmd, input logic [WORD_W-1:0] word);
      offer_word(cmd, word, 1'b0, '0);
   endtask

   // Runs any frame in flight to its end, then lets every response drain.
   task automatic settle_block();
      while (tx_state != TX_IDLE) begin
         drive_word(CMD_TICK, any_command_word());
      end
      req_valid <= 1'b0;
      while (expected_lines.size() != 0) begin
         @(posedge clock);
      end
      repeat (4) @(posedge clock);
   endtask

   task automatic write_register(input logic [1:0] index, input logic [CSR_DATA_W-1:0] value);
      logic [CSR_DATA_W-1:0] readback;
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {index, 2'b00};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_pwrite <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      readback = csr_prdata;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
      case (index)
         REG_ALLOW_NO_RX: cfg.allow_no_rx = value[0];
         REG_HOLDOFF_TX:  cfg.holdoff_tx = value[CNT_W-1:0];
         REG_HOLDOFF_RX:  cfg.holdoff_rx = value[CNT_W-1:0];
         default:         cfg.tail_ticks = value[CNT_W-1:0];
      endcase
      if (readback !== value) begin
         count_error($sformatf("register %0d read exp %h act %h", index, value, readback));
      end
   endtask

   initial begin : response_ready
      int hold_left;
      hold_left = 0;
      rsp_ready = 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_hold_request != 0) begin
            hold_left = rsp_hold_request;
            rsp_hold_request = 0;
         end
         if (hold_left > 0) begin
            rsp_ready <= 1'b0;
            hold_left--;
         end else begin
            rsp_ready <= ($urandom_range(99) >= rsp_idle_pct);
         end
      end
   end

   initial begin : response_checker
      line_result_type seen;
      line_result_type want;
      logic            taken;
      forever begin
         @(negedge clock);
         taken = (rsp_valid === 1'b1) && (rsp_ready === 1'b1) && (reset === 1'b0);
         seen = '{rsp_line_level, rsp_driver_enable, rsp_busy_res, rsp_enqueue_ok,
                  rsp_sent_done, rsp_sent_word, rsp_queue_count};
         @(posedge clock);
         if (taken) begin
            if (expected_lines.size() == 0) begin
               count_error($sformatf("response word with none pending: %h", seen));
            end else begin
               want = expected_lines.pop_front();
               if (seen !== want) begin
                  count_error($sformatf(
                     {"level %b/%b enable %b/%b busy %b/%b enq_ok %b/%b done %b/%b ",
                      "sent %h/%h count %0d/%0d (exp/act)"},
                     want.line_level, seen.line_level, want.driver_enable,
                     seen.driver_enable, want.busy_res, seen.busy_res,
                     want.enqueue_ok, seen.enqueue_ok, want.sent_done, seen.sent_done,
                     want.sent_word, seen.sent_word, want.queue_count, seen.queue_count));
               end
            end
         end
      end
   end

   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("DONE: errors detected");
      $finish;
   end

   initial begin : stimulus
      int              phase;
      int              n;
      int              pick;
      directed_row_type row;
      reset = 1'b1;
      req_valid = 1'b0;
      req_command = CMD_TICK;
      req_command_word = '0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      req_idle_pct = 14;
      rsp_idle_pct = 75;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (n = 0; n < DIRECTED_ROWS; n++) begin
         row = directed_rows[n];
         offer_word(row.command, row.word, row.typed,
                    '{row.level, row.enable, row.busy, row.accepted, row.done,
                      row.sent, row.count});
      end

      for (phase = 0; phase < PHASES; phase++) begin
         settle_block();
         write_register(REG_ALLOW_NO_RX, CSR_DATA_W'(phase_allow[phase]));
         write_register(REG_HOLDOFF_TX, CSR_DATA_W'(phase_hold_tx[phase]));
         write_register(REG_HOLDOFF_RX, CSR_DATA_W'(phase_hold_rx[phase]));
         write_register(REG_TAIL_TICKS, CSR_DATA_W'(phase_tail[phase]));
         case (phase / 2)
            0: begin
               req_idle_pct = 14;
               rsp_idle_pct = 75;
            end
            1: begin
               req_idle_pct = 75;
               rsp_idle_pct = 14;
            end
            default: begin
               req_idle_pct = 0;
               rsp_idle_pct = 0;
            end
         endcase
         if (phase == 0) begin
            rsp_hold_request = 400;
         end
         for (n = 0; n < WORDS_PER_PHASE; n++) begin
            pick = $urandom_range(99);
            if (pick < 2) begin
               repeat (QUEUE_DEPTH + 2) drive_word(CMD_ENQUEUE, any_command_word());
            end else if (pick < 80) begin
               drive_word(CMD_TICK, any_command_word());
            end else if (pick < 92) begin
               drive_word(CMD_ENQUEUE, any_command_word());
            end else if (pick < 97) begin
               drive_word(CMD_RECEIVE, any_command_word());
            end else begin
               drive_word(CMD_RESERVED, any_command_word());
            end
         end
      end
      settle_block();

      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

`default_nettype wire

// File: filelist.f
+incdir+rtl
rtl/pwct_pkg.sv
rtl/pwct_ram.sv
rtl/pwct_queue.sv
rtl/pwct_seq.sv
rtl/pulse_width_command_transmitter.sv
sim/tb_pulse_width_command_transmitter.sv
